>>> hdl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Boundary mark format, command codes, walker states and result beat struct.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MARK_W   = 9;
  localparam int MARK_HDR = 2;

  typedef logic signed [MARK_W-1:0] mark_t;

  localparam mark_t MARK_MAX = 9'sd255;
  localparam mark_t MARK_MIN = -9'sd256;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_EVAL,
    ST_A_NCHK,
    ST_A_SPLIT,
    ST_A_TAKE,
    ST_F_RD,
    ST_F_WR
  } walk_state_e;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [7:0] offset;
  } res_t;

  // clamp a widened mark back into the 9-bit signed range
  function automatic mark_t sat_mark(input logic signed [11:0] v);
    mark_t r;
    if (v > 12'sd255) begin
      r = MARK_MAX;
    end else if (v < -12'sd256) begin
      r = MARK_MIN;
    end else begin
      r = v[MARK_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram: generic simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int Width = 9,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/ffba_walker.sv
// ----------------------------------------------------------------------------
// ffba_walker: chunk walk sequencer of the allocator
// Clears the mark memory after reset, then walks, merges, splits and frees
// chunks with one mark read or write per cycle.
// ----------------------------------------------------------------------------
module ffba_walker import ffba_pkg::*; #(
  parameter int RegionBytes = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           command_i,
  input  logic [7:0]                     request_bytes_i,
  input  logic [7:0]                     data_offset_i,
  output logic                           busy_o,
  output res_t                           res_o,
  output logic                           we_o,
  output logic [$clog2(RegionBytes)-1:0] waddr_o,
  output mark_t                          wdata_o,
  output logic                           re_o,
  output logic [$clog2(RegionBytes)-1:0] raddr_o,
  input  mark_t                          rdata_i
);

  localparam int AW = $clog2(RegionBytes);
  // walk position may step past the region end by up to one chunk
  localparam int PW = $clog2(RegionBytes + 512);
  localparam int InitMark = (RegionBytes - MARK_HDR > 255) ? 255
                                                           : RegionBytes - MARK_HDR;
  localparam mark_t INIT_MARK = MARK_W'(InitMark);
  localparam logic [PW-1:0] REGION_END = PW'(RegionBytes);
  localparam logic [PW-1:0] HDR = PW'(MARK_HDR);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RegionBytes - 1);

  walk_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] nxt_q, nxt_d;
  logic [7:0]    need_q, need_d;
  mark_t         m_q, m_d;

  // evaluation of the current chunk
  mark_t                 m_sel;
  logic                  fit;
  logic [7:0]            rest;
  logic                  rest_big;
  logic [PW-1:0]         nxt_pos;
  logic [PW-1:0]         skip_pos;
  logic [MARK_W:0]       m_neg;
  logic                  pos_out;
  logic                  nxt_out;
  logic [PW-1:0]         split_pos;
  logic signed [11:0]    merged;
  logic signed [11:0]    freed;

  assign m_sel     = (state_q == ST_A_CHK) ? rdata_i : m_q;
  assign fit       = $signed({m_sel[MARK_W-1], m_sel}) >= $signed({2'b00, need_q});
  assign rest      = m_sel[7:0] - need_q;
  assign rest_big  = rest >= 8'(MARK_HDR);
  assign m_neg     = -{m_sel[MARK_W-1], m_sel};
  assign nxt_pos   = pos_q + PW'(m_sel[7:0]) + HDR;
  assign skip_pos  = pos_q + PW'(m_neg[MARK_W-1:0]) + HDR;
  assign pos_out   = pos_q >= REGION_END;
  assign nxt_out   = nxt_pos >= REGION_END;
  assign split_pos = pos_q + HDR + PW'(need_q);
  assign merged    = 12'(m_q) + 12'(rdata_i) + 12'sd2;
  assign freed     = -12'(rdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    nxt_q  <= nxt_d;
    need_q <= need_d;
    m_q    <= m_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          if (command_i == CMD_ALLOC) begin
            if (request_bytes_i != 8'd0) state_d = ST_A_RD;
          end else if (data_offset_i >= 8'(MARK_HDR)) begin
            state_d = ST_F_RD;
          end
        end
      end
      ST_A_RD:  state_d = pos_out ? ST_IDLE : ST_A_CHK;
      ST_A_CHK, ST_A_EVAL: begin
        if (fit) begin
          state_d = rest_big ? ST_A_SPLIT : ST_A_TAKE;
        end else if (m_sel[MARK_W-1] || nxt_out) begin
          state_d = ST_A_RD;
        end else begin
          state_d = ST_A_NCHK;
        end
      end
      ST_A_NCHK:  state_d = rdata_i[MARK_W-1] ? ST_A_RD : ST_A_EVAL;
      ST_A_SPLIT: state_d = ST_A_TAKE;
      ST_A_TAKE:  state_d = ST_IDLE;
      ST_F_RD:    state_d = pos_out ? ST_IDLE : ST_F_WR;
      ST_F_WR:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // memory access, datapath and result beat
  always_comb begin
    clr_d   = clr_q;
    pos_d   = pos_q;
    nxt_d   = nxt_q;
    need_d  = need_q;
    m_d     = m_q;
    we_o    = 1'b0;
    waddr_o = pos_q[AW-1:0];
    wdata_o = '0;
    re_o    = 1'b0;
    raddr_o = pos_q[AW-1:0];
    res_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = clr_q;
        wdata_o = (clr_q == '0) ? INIT_MARK : '0;
        clr_d   = clr_q + AW'(1);
      end
      ST_IDLE: begin
        need_d = request_bytes_i;
        pos_d  = (command_i == CMD_ALLOC) ? '0 : PW'(data_offset_i - 8'(MARK_HDR));
        if (start_i) begin
          if (command_i == CMD_ALLOC) begin
            res_o.valid = request_bytes_i == 8'd0;
          end else if (data_offset_i < 8'(MARK_HDR)) begin
            res_o.valid = 1'b1;
          end
        end
      end
      ST_A_RD: begin
        re_o = !pos_out;
        res_o.valid = pos_out;
      end
      ST_A_CHK, ST_A_EVAL: begin
        m_d = m_sel;
        if (!fit) begin
          if (m_sel[MARK_W-1]) begin
            pos_d = skip_pos;
          end else if (nxt_out) begin
            pos_d = nxt_pos;
          end else begin
            nxt_d   = nxt_pos;
            re_o    = 1'b1;
            raddr_o = nxt_pos[AW-1:0];
          end
        end
      end
      ST_A_NCHK: begin
        if (rdata_i[MARK_W-1]) begin
          pos_d = nxt_q;
        end else begin
          we_o    = 1'b1;
          wdata_o = sat_mark(merged);
          m_d     = sat_mark(merged);
        end
      end
      ST_A_SPLIT: begin
        we_o    = split_pos < REGION_END;
        waddr_o = split_pos[AW-1:0];
        wdata_o = MARK_W'(rest - 8'(MARK_HDR));
      end
      ST_A_TAKE: begin
        we_o       = 1'b1;
        wdata_o    = rest_big ? -$signed({1'b0, need_q}) : m_neg[MARK_W-1:0];
        res_o.valid  = 1'b1;
        res_o.ok     = 1'b1;
        res_o.offset = pos_q[7:0] + 8'(MARK_HDR);
      end
      ST_F_RD: begin
        re_o        = !pos_out;
        res_o.valid = pos_out;
        res_o.ok    = 1'b1;
      end
      ST_F_WR: begin
        we_o        = 1'b1;
        wdata_o     = sat_mark(freed);
        res_o.valid = 1'b1;
        res_o.ok    = 1'b1;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  assign busy_o = state_q != ST_IDLE;

endmodule

>>> hdl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit allocator over a marked byte region
// Implicit free list of chunks, each opened by a signed two-byte boundary mark,
// held in one mark memory and walked one read or write per cycle.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | beat contents
//  ---------+-----------------------+------------------------------------------
//  command  | start, busy           | command_i, request_bytes_i, data_offset_i
//  result   | result_valid_o strobe | ok_o, granted_offset_o
//
//  after reset the mark memory is swept once, with busy high
//  free: the mark is read, then written back negated with the result beat; an
//    offset below two and a zero-byte allocate are refused at accept, and an
//    offset outside the region is answered from the read step
//  allocate: each chunk mark is read and checked; a used chunk is skipped, a
//    free chunk too small reads its successor unless that lies past the end
//    and merges with it if free; the chosen chunk gets a split mark if needed
//    and a used mark; a walk past the end is refused; results are registered
//  one command at a time: busy stays high until the result beat is produced
//  results are strobed for one cycle and cannot be held off by the receiver
//
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int RegionBytes = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       command_i,
  input  logic [7:0] request_bytes_i,
  input  logic [7:0] data_offset_i,
  output logic       result_valid_o,
  output logic       ok_o,
  output logic [7:0] granted_offset_o
);

  localparam int AW = $clog2(RegionBytes);

  logic          walk_busy;
  res_t          res;
  logic          we;
  logic [AW-1:0] waddr;
  mark_t         wdata;
  logic          re;
  logic [AW-1:0] raddr;
  mark_t         rdata;

  logic          valid_q;
  logic          ok_q;
  logic [7:0]    offset_q;

  // sequencer: reset sweep, chunk walk, merge, split and free
  ffba_walker #(
    .RegionBytes(RegionBytes)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .command_i      (command_i),
    .request_bytes_i(request_bytes_i),
    .data_offset_i  (data_offset_i),
    .busy_o         (walk_busy),
    .res_o          (res),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  // one mark per byte offset
  ffba_ram #(
    .Width(MARK_W),
    .Depth(RegionBytes)
  ) u_marks (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // result beat register, strobe is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= res.ok;
    offset_q <= res.offset;
  end

  assign busy             = walk_busy;
  assign result_valid_o   = valid_q;
  assign ok_o             = ok_q;
  assign granted_offset_o = offset_q;

`ifndef NO_ASSERTIONS
  // a refused beat never carries an offset
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !ok_o |-> granted_offset_o == 8'd0)
    else $error("refused beat carries an offset");

  // a zero-byte allocate is refused on the next cycle
  a_zero_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == CMD_ALLOC && request_bytes_i == 8'd0
    |=> result_valid_o && !ok_o)
    else $error("zero-byte allocate not refused at once");

  // every result beat follows a command in progress or just accepted
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy || start))
    else $error("result beat without a command");
`endif

endmodule
